### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the SLIP frame decoder: line codes, result
// status codes, the result word and the output buffer geometry.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// SLIP line codes: frame end, escape, escaped end, escaped escape
	localparam logic [7:0] CODE_FEND  = 8'hC0;
	localparam logic [7:0] CODE_FESC  = 8'hDB;
	localparam logic [7:0] CODE_TFEND = 8'hDC;
	localparam logic [7:0] CODE_TFESC = 8'hDD;

	// Default frame store depth and limit register reset value
	localparam int          BUF_DEPTH_DEF   = 256;
	localparam logic [8:0]  FRAME_LIMIT_RST = 9'd256;

	// Output buffer: three words keep a full-rate stream going with a
	// registered stall toward the sender
	localparam int OBUF_DEPTH = 3;
	localparam int OBUF_AW    = $clog2(OBUF_DEPTH);

	typedef enum logic [1:0] {
		ST_WAIT     = 2'd0,
		ST_READY    = 2'd1,
		ST_PROT_ERR = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] msg_length;
		logic [7:0] read_data;
	} result_t;

endpackage

### rtl/sfd_out_buf.sv
// ----------------------------------------------------------------------------
// sfd_out_buf
// Small output queue for result words. Reports its fill level so the
// decoder can throttle its input from registered state only.
// ----------------------------------------------------------------------------
module sfd_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  sfd_pkg::result_t            push_data,
	input  logic                        out_stall,
	output logic                        out_valid,
	output sfd_pkg::result_t            out_data,
	output logic [sfd_pkg::OBUF_AW-1:0] level
);

	localparam int AW = sfd_pkg::OBUF_AW;
	localparam logic [AW-1:0] LAST = AW'(sfd_pkg::OBUF_DEPTH - 1);

	sfd_pkg::result_t entry_q [sfd_pkg::OBUF_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] count_q;
	logic          pop;

	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign level     = count_q;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/slip_frame_decoder.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder
// SLIP receive decoder. Fed bytes are unescaped into a frame store memory;
// an unescaped END reports the frame length, bad escapes and overlong
// frames are flagged. A read word returns one stored byte.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_stall  | action, rx_byte, read_index
//  out     | out_valid / out_stall| status, msg_length, read_data
//  cfg     | cfg_valid / cfg_ready| frame_limit
//
//  One input word per cycle while in_stall is low; each result passes through
//  stage 1 (where the frame store is read) and then the output queue.
//  Decode flags and byte count update in the accept cycle, so the next
//  word sees them at once; the store read and write share that same edge.
//  Reset clears flags, count and queue and sets the limit to 256; the store is not cleared.
//  in_stall rises once the three-word output queue plus the word in flight
//  fill it; it comes from registers only.
//
module slip_frame_decoder #(
	parameter int BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// input words
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	// result words
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] msg_length,
	output logic [7:0] read_data,
	// limit register write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] frame_limit
);

	localparam int CW = $clog2(BUF_DEPTH);
	localparam int EW = (CW + 1 > 9) ? CW + 1 : 9;
	localparam logic [EW-1:0] DEPTH_E = EW'(BUF_DEPTH);

	// control state
	logic [8:0]    frame_limit_q;
	logic [CW-1:0] count_q;
	logic          esc_q;
	logic          ready_q;

	// stage 1
	logic             valid_s1;
	sfd_pkg::status_t status_s1;
	logic [7:0]       len_s1;
	logic             rd_sel_s1;
	logic [7:0]       rd_data_s1;

	// frame store
	logic [7:0] frame_mem [BUF_DEPTH];

	logic                        accept;
	logic                        feed;
	logic [CW-1:0]               base_cnt;
	logic [CW:0]                 next_cnt;
	logic [EW-1:0]               lim_ext;
	logic [EW-1:0]               eff_limit;
	logic                        inc;
	logic                        wr_en;
	logic [7:0]                  wr_data;
	logic                        esc_d;
	logic                        ready_d;
	logic [CW-1:0]               count_d;
	sfd_pkg::status_t            status_d;
	logic [7:0]                  len_d;
	logic                        rd_in_range;
	logic [CW-1:0]               rd_addr;
	sfd_pkg::result_t            res_s1;
	sfd_pkg::result_t            res_out;
	logic [sfd_pkg::OBUF_AW-1:0] obuf_level;
	logic [sfd_pkg::OBUF_AW:0]   occupancy;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign feed      = accept && !action;

	// hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= sfd_pkg::FRAME_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			frame_limit_q <= frame_limit;
		end
	end

	// clamp the limit to the store depth; a zero limit also selects the depth
	always_comb begin
		lim_ext   = EW'(frame_limit_q);
		eff_limit = (frame_limit_q == '0 || lim_ext > DEPTH_E) ? DEPTH_E : lim_ext;
	end

	// decode one fed byte
	always_comb begin
		base_cnt = ready_q ? '0 : count_q;
		inc      = 1'b0;
		wr_en    = 1'b0;
		wr_data  = rx_byte;
		esc_d    = 1'b0;
		ready_d  = 1'b0;
		status_d = sfd_pkg::ST_WAIT;
		if (esc_q) begin
			if (rx_byte == sfd_pkg::CODE_TFESC) begin
				wr_en   = 1'b1;
				wr_data = sfd_pkg::CODE_FESC;
				inc     = 1'b1;
			end else if (rx_byte == sfd_pkg::CODE_TFEND) begin
				wr_en   = 1'b1;
				wr_data = sfd_pkg::CODE_FEND;
				inc     = 1'b1;
			end else begin
				status_d = sfd_pkg::ST_PROT_ERR;
			end
		end else if (rx_byte == sfd_pkg::CODE_FEND) begin
			ready_d  = 1'b1;
			status_d = sfd_pkg::ST_READY;
		end else if (rx_byte == sfd_pkg::CODE_FESC) begin
			esc_d = 1'b1;
		end else begin
			wr_en = 1'b1;
			inc   = 1'b1;
		end
		next_cnt = {1'b0, base_cnt} + (CW + 1)'(inc);
		if (EW'(next_cnt) >= eff_limit) begin
			count_d  = '0;
			status_d = sfd_pkg::ST_TOO_LONG;
		end else begin
			count_d = next_cnt[CW-1:0];
		end
		len_d = ready_d ? 8'(count_d) : 8'd0;
	end

	// update decode state on fed bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			esc_q   <= 1'b0;
			ready_q <= 1'b0;
		end else if (feed) begin
			count_q <= count_d;
			esc_q   <= esc_d;
			ready_q <= ready_d;
		end
	end

	assign rd_in_range = (32'(read_index) < BUF_DEPTH);
	assign rd_addr     = CW'(read_index);

	// frame store: write at the count, read at the index
	always_ff @(posedge clk) begin
		if (feed && wr_en) begin
			frame_mem[base_cnt] <= wr_data;
		end
		if (accept && action) begin
			rd_data_s1 <= frame_mem[rd_addr];
		end
	end

	// advance stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (action) begin
				status_s1 <= sfd_pkg::ST_WAIT;
				len_s1    <= ready_q ? 8'(count_q) : 8'd0;
				rd_sel_s1 <= rd_in_range;
			end else begin
				status_s1 <= status_d;
				len_s1    <= len_d;
				rd_sel_s1 <= 1'b0;
			end
		end
	end

	// build the result word
	always_comb begin
		res_s1.status     = status_s1;
		res_s1.msg_length = len_s1;
		res_s1.read_data  = rd_sel_s1 ? rd_data_s1 : 8'd0;
	end

	sfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res_s1),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (res_out),
		.level     (obuf_level)
	);

	// stall input when queue plus the word in flight could overflow
	assign occupancy = {1'b0, obuf_level} + (sfd_pkg::OBUF_AW + 1)'(valid_s1);
	assign in_stall  = (occupancy >= (sfd_pkg::OBUF_AW + 1)'(sfd_pkg::OBUF_DEPTH));

	assign status     = res_out.status;
	assign msg_length = res_out.msg_length;
	assign read_data  = res_out.read_data;

endmodule

### rtl/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the SLIP frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] msg_length,
	input logic [7:0] read_data
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({status, msg_length, read_data}))
		else $error("result word changed while stalled");

	// error and abort results never carry a length
	a_err_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sfd_pkg::ST_PROT_ERR || status == sfd_pkg::ST_TOO_LONG)
		|-> msg_length == 8'd0)
		else $error("length reported with error status");

	// read data only comes with a read reply
	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != 8'd0 |-> status == sfd_pkg::ST_WAIT)
		else $error("read data with non-read status");

	// input stalls only while results are queued
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SLIP frame decoder. A queue of input words is
// filled with a directed set (escapes, bad escapes, empty frames, reads,
// limit extremes and a limit lowered mid-frame), then with random phases of
// well-formed frames, reads of written bytes and line noise under several
// frame limits. A driver and a monitor with random idling and stalls move
// the words. Each taken word is decoded by a local model whose result is
// compared field by field with the block's result words, in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STORE_DEPTH     = sfd_pkg::BUF_DEPTH_DEF;
	localparam int ITEMS_PER_PHASE = 340;
	localparam int NUM_PHASES      = 5;

	typedef struct packed {
		logic       action;
		logic [7:0] rx;
		logic [7:0] ridx;
	} slip_word_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic       action      = 1'b0;
	logic [7:0] rx_byte     = 8'd0;
	logic [7:0] read_index  = 8'd0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [1:0] status;
	logic [7:0] msg_length;
	logic [7:0] read_data;
	logic       cfg_valid   = 1'b0;
	logic       cfg_ready;
	logic [8:0] frame_limit = 9'd0;

	// stimulus and expectations
	slip_word_t       word_q[$];
	sfd_pkg::result_t result_q[$];
	int               queued_words = 0;
	int               idle_pct     = 0;
	int               stall_pct    = 0;
	logic             word_taken   = 1'b0;
	bit               failed       = 1'b0;

	// decoder model state
	int unsigned line_count  = 0;
	logic        esc_seen    = 1'b0;
	logic        frame_done  = 1'b0;
	logic [8:0]  limit_reg   = sfd_pkg::FRAME_LIMIT_RST;
	logic [7:0]  shadow_store [STORE_DEPTH];
	bit          store_written [STORE_DEPTH];
	int          written_idx[$];

	slip_frame_decoder #(
		.BUF_DEPTH(STORE_DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.rx_byte    (rx_byte),
		.read_index (read_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.msg_length (msg_length),
		.read_data  (read_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.frame_limit(frame_limit)
	);

	always #6 clk = ~clk;

	// Store one decoded byte at the current count and remember the slot
	function automatic void store_byte(input logic [7:0] v);
		if (line_count < STORE_DEPTH) begin
			shadow_store[line_count] = v;
			if (!store_written[line_count]) begin
				store_written[line_count] = 1'b1;
				written_idx.push_back(line_count);
			end
		end
	endfunction

	// Decode one taken word and return the result it must produce
	function automatic sfd_pkg::result_t decode_word(input slip_word_t w);
		sfd_pkg::result_t r;
		int unsigned      lim;
		r   = '{sfd_pkg::ST_WAIT, 8'd0, 8'd0};
		lim = (limit_reg == 9'd0 || limit_reg > STORE_DEPTH) ? STORE_DEPTH : limit_reg;
		if (w.action) begin
			r.read_data = shadow_store[w.ridx];
		end else begin
			// a word after a finished frame starts a new one
			if (frame_done) begin
				line_count = 0;
				frame_done = 1'b0;
			end
			if (esc_seen) begin
				if (w.rx == sfd_pkg::CODE_TFESC)
					store_byte(sfd_pkg::CODE_FESC);
				else if (w.rx == sfd_pkg::CODE_TFEND)
					store_byte(sfd_pkg::CODE_FEND);
				else
					r.status = sfd_pkg::ST_PROT_ERR;
				esc_seen = 1'b0;
			end else if (w.rx == sfd_pkg::CODE_FEND) begin
				frame_done = 1'b1;
				r.status   = sfd_pkg::ST_READY;
			end else if (w.rx == sfd_pkg::CODE_FESC) begin
				esc_seen = 1'b1;
			end else begin
				store_byte(w.rx);
			end
			if (r.status == sfd_pkg::ST_WAIT && w.rx != sfd_pkg::CODE_FESC)
				line_count++;
			if (line_count >= lim) begin
				line_count = 0;
				r.status   = sfd_pkg::ST_TOO_LONG;
			end
		end
		r.msg_length = frame_done ? 8'(line_count) : 8'd0;
		return r;
	endfunction

	function automatic void push_feed(input logic [7:0] b);
		word_q.push_back('{1'b0, b, 8'($urandom_range(255))});
		queued_words++;
	endfunction

	function automatic void push_read(input int idx);
		word_q.push_back('{1'b1, 8'($urandom_range(255)), 8'(idx)});
		queued_words++;
	endfunction

	function automatic logic [7:0] pick_code();
		case ($urandom_range(3))
			0: return sfd_pkg::CODE_FEND;
			1: return sfd_pkg::CODE_FESC;
			2: return sfd_pkg::CODE_TFEND;
			default: return sfd_pkg::CODE_TFESC;
		endcase
	endfunction

	// Hold until every queued word is taken and every result is back
	task automatic wait_idle();
		while (word_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_frame_limit(input logic [8:0] v);
		@(negedge clk);
		cfg_valid   <= 1'b1;
		frame_limit <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		limit_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Driver: advance to the next word once the current one is taken
	always @(negedge clk) begin : drive
		slip_word_t w;
		if (!in_valid || word_taken) begin
			if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				w = word_q.pop_front();
				in_valid   <= 1'b1;
				action     <= w.action;
				rx_byte    <= w.rx;
				read_index <= w.ridx;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Monitor: predict on each taken input word, check each result word
	always @(posedge clk) begin : watch
		slip_word_t       seen;
		sfd_pkg::result_t want;
		if (arst_n) begin
			word_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				seen = '{action, rx_byte, read_index};
				result_q.push_back(decode_word(seen));
			end
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$display("%t unexpected result word: status %0d length %0d data %0d",
						$time, status, msg_length, read_data);
					failed = 1'b1;
				end else begin
					want = result_q.pop_front();
					if (status !== want.status) begin
						$display("%t status: expected %0d, got %0d", $time, want.status, status);
						failed = 1'b1;
					end
					if (msg_length !== want.msg_length) begin
						$display("%t msg_length: expected %0d, got %0d",
							$time, want.msg_length, msg_length);
						failed = 1'b1;
					end
					if (read_data !== want.read_data) begin
						$display("%t read_data: expected 0x%02h, got 0x%02h",
							$time, want.read_data, read_data);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// Stimulus
	initial begin : stim
		int         ph;
		int         pick;
		int         len;
		int         k;
		logic [7:0] b;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// escapes, a frame, reads of it, bad escapes, raw code bytes, empty frame
		push_feed(8'h00);
		push_feed(8'hFF);
		push_feed(sfd_pkg::CODE_FESC);
		push_feed(sfd_pkg::CODE_TFEND);
		push_feed(sfd_pkg::CODE_FESC);
		push_feed(sfd_pkg::CODE_TFESC);
		push_feed(sfd_pkg::CODE_FEND);
		push_read(0);
		push_read(1);
		push_read(2);
		push_read(3);
		push_feed(sfd_pkg::CODE_FESC);
		push_feed(8'h41);
		push_feed(sfd_pkg::CODE_FESC);
		push_feed(sfd_pkg::CODE_FEND);
		push_feed(sfd_pkg::CODE_TFEND);
		push_feed(sfd_pkg::CODE_TFESC);
		push_feed(sfd_pkg::CODE_FEND);
		push_feed(sfd_pkg::CODE_FEND);
		wait_idle();

		// smallest limit: every stored byte aborts
		set_frame_limit(9'd1);
		push_feed(8'h5A);
		push_feed(sfd_pkg::CODE_FEND);
		wait_idle();

		// out-of-range limit, then lower it below the open frame's count
		set_frame_limit(9'd511);
		for (k = 0; k < 5; k++)
			push_feed(8'h30 + 8'(k));
		wait_idle();
		set_frame_limit(9'd2);
		push_feed(8'h33);
		wait_idle();
		set_frame_limit(9'd256);

		// random phases
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 49;
					stall_pct = 0;
					set_frame_limit(9'($urandom_range(2, 48)));
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 49;
					set_frame_limit(9'd511);
				end
				3: begin
					idle_pct  = 32;
					stall_pct = 32;
					set_frame_limit(9'd0);
				end
				default: begin
					idle_pct  = 0;
					stall_pct = 0;
					set_frame_limit(9'($urandom_range(1, 300)));
				end
			endcase
			queued_words = 0;
			while (queued_words < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					// well-formed frame, now and then one that fills the store
					len = ($urandom_range(24) == 0) ? $urandom_range(240, 270)
						: $urandom_range(24);
					for (k = 0; k < len; k++) begin
						b = ($urandom_range(7) == 0) ? pick_code() : 8'($urandom_range(255));
						if (b == sfd_pkg::CODE_FEND) begin
							push_feed(sfd_pkg::CODE_FESC);
							push_feed(sfd_pkg::CODE_TFEND);
						end else if (b == sfd_pkg::CODE_FESC) begin
							push_feed(sfd_pkg::CODE_FESC);
							push_feed(sfd_pkg::CODE_TFESC);
						end else begin
							push_feed(b);
						end
					end
					push_feed(sfd_pkg::CODE_FEND);
				end else if (pick < 82) begin
					push_read(written_idx[$urandom_range(written_idx.size() - 1)]);
				end else if (pick < 90) begin
					// escape with a random follower, mostly a bad one
					push_feed(sfd_pkg::CODE_FESC);
					push_feed(8'($urandom_range(255)));
				end else begin
					push_feed($urandom_range(1) ? pick_code() : 8'($urandom_range(255)));
				end
			end
			// sender pauses until the block has returned everything
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (!failed)
			$display("slip_frame_decoder verification clean");
		else
			$display("slip_frame_decoder verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("slip_frame_decoder verification failed");
		$finish;
	end

endmodule
